### design/cell_energy_floor_limiter_core_macros.svh
// assertion macros for the energy floor limiter core
`ifndef CELL_ENERGY_FLOOR_LIMITER_CORE_MACROS_SVH
`define CELL_ENERGY_FLOOR_LIMITER_CORE_MACROS_SVH

// clocked assertion, off while in reset
`define CEFL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define CEFL_IMPLIES(name, ante, cons, msg) \
  `CEFL_ASSERT(name, (ante) |-> (cons), msg)

`endif

### design/cefl_pkg.sv
// shared types, constants and helpers for the energy floor limiter
package cefl_pkg;

  localparam int DW         = 32;
  localparam int FB         = 16;
  localparam int SQ_W       = 47;
  localparam int SUM_W      = 48;
  localparam int Q_W        = 64;
  localparam int CFG_W      = 31;
  localparam int DIV_STAGES = Q_W;
  localparam int PADDR_W    = 5;

  localparam logic [1:0] HM_ZEUS = 2'd0;
  localparam logic [1:0] HM_ORD  = 2'd1;
  localparam logic [1:0] HM_MHD  = 2'd2;

  typedef enum logic [2:0] {
    REG_HYDRO_MODE   = 3'd0,
    REG_DUAL_ENERGY  = 3'd1,
    REG_MHD_ENABLED  = 3'd2,
    REG_ENERGY_FLOOR = 3'd3,
    REG_ALFVEN_SQ    = 3'd4,
    REG_ALFVEN_SQ_INV = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DW-1:0] rho;
    logic signed [DW-1:0] etot;
    logic signed [DW-1:0] gas;
    logic [SQ_W-1:0]      kin;
    logic signed [DW-1:0] rho_lim;
    logic                 rho_pos;
  } side_t;

  function automatic logic [DW-1:0] sat_pos(input logic [Q_W-1:0] v);
    logic [DW-1:0] r;
    r = (|v[Q_W-1:DW-1]) ? {1'b0, {(DW-1){1'b1}}} : v[DW-1:0];
    return r;
  endfunction

endpackage

### design/cefl_front.sv
// front stages: squares, sums, limiter density product
module cefl_front
  import cefl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_density,
  input  logic signed [DW-1:0] in_vel_x,
  input  logic signed [DW-1:0] in_vel_y,
  input  logic signed [DW-1:0] in_vel_z,
  input  logic signed [DW-1:0] in_mag_x,
  input  logic signed [DW-1:0] in_mag_y,
  input  logic signed [DW-1:0] in_mag_z,
  input  logic signed [DW-1:0] in_total_energy,
  input  logic signed [DW-1:0] in_gas_energy,
  input  logic                 mhd_en,
  input  logic [CFG_W-1:0]     asq_inv,
  output logic                 fr_valid,
  output side_t                fr_side,
  output logic [Q_W-1:0]       fr_dvd,
  output logic [CFG_W-1:0]     fr_dvs
);

  logic signed [DW-1:0] comp [6];
  logic [DW-1:0]        mag [6];
  logic [SQ_W-1:0]      sq_r [6];
  logic [2*DW-1:0]      prod [6];
  logic signed [DW-1:0] rho1_r, etot1_r, gas1_r;
  logic                 v1_r;

  logic [SUM_W-1:0]     v2_nxt, b2_nxt;
  logic [SUM_W-1:0]     b2_2_r;
  logic [SQ_W-1:0]      kin2_r;
  logic signed [DW-1:0] rho2_r, etot2_r, gas2_r;
  logic                 v2v_r;

  logic [SUM_W/2+CFG_W-1:0] plo3_r, phi3_r;
  logic [SUM_W-1:0]     b2_3_r;
  logic [SQ_W-1:0]      kin3_r;
  logic signed [DW-1:0] rho3_r, etot3_r, gas3_r;
  logic                 v3_r;

  logic [SUM_W+CFG_W-1:0] lim_prod;
  logic [SUM_W+CFG_W-FB-1:0] lim_q;
  logic signed [DW-1:0] rho_lim;
  logic                 rho_pos;
  side_t                side4_r;
  logic [Q_W-1:0]       dvd4_r;
  logic [CFG_W-1:0]     dvs4_r;
  logic                 v4_r;

  always_comb begin
    comp[0] = in_vel_x;
    comp[1] = in_vel_y;
    comp[2] = in_vel_z;
    comp[3] = in_mag_x;
    comp[4] = in_mag_y;
    comp[5] = in_mag_z;
    for (int i = 0; i < 6; i++) begin
      mag[i]  = comp[i][DW-1] ? DW'(-comp[i]) : DW'(comp[i]);
      prod[i] = mag[i] * mag[i];
    end
  end

  always_comb begin
    v2_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    b2_nxt = mhd_en ? SUM_W'(sq_r[3]) + SUM_W'(sq_r[4]) + SUM_W'(sq_r[5]) : '0;
  end

  always_comb begin
    lim_prod = (SUM_W+CFG_W)'(plo3_r) + ((SUM_W+CFG_W)'(phi3_r) << (SUM_W/2));
    lim_q    = lim_prod[SUM_W+CFG_W-1:FB];
    rho_lim  = (|lim_q[SUM_W+CFG_W-FB-1:DW-1]) ? {1'b0, {(DW-1){1'b1}}}
                                               : $signed(lim_q[DW-1:0]);
    rho_pos  = !rho3_r[DW-1] && (rho3_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2v_r <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      v2v_r <= v1_r;
      v3_r  <= v2v_r;
      v4_r  <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        sq_r[i] <= prod[i][SQ_W+FB-1:FB];
      end
      rho1_r  <= in_density;
      etot1_r <= in_total_energy;
      gas1_r  <= in_gas_energy;

      b2_2_r  <= b2_nxt;
      kin2_r  <= v2_nxt[SUM_W-1:1];
      rho2_r  <= rho1_r;
      etot2_r <= etot1_r;
      gas2_r  <= gas1_r;

      plo3_r  <= b2_2_r[SUM_W/2-1:0] * asq_inv;
      phi3_r  <= b2_2_r[SUM_W-1:SUM_W/2] * asq_inv;
      b2_3_r  <= b2_2_r;
      kin3_r  <= kin2_r;
      rho3_r  <= rho2_r;
      etot3_r <= etot2_r;
      gas3_r  <= gas2_r;

      side4_r.rho     <= rho3_r;
      side4_r.etot    <= etot3_r;
      side4_r.gas     <= gas3_r;
      side4_r.kin     <= kin3_r;
      side4_r.rho_lim <= rho_lim;
      side4_r.rho_pos <= rho_pos;
      dvd4_r <= {b2_3_r, {FB{1'b0}}};
      dvs4_r <= rho_pos ? rho3_r[CFG_W-1:0] : CFG_W'(1);
    end
  end

  assign fr_valid = v4_r;
  assign fr_side  = side4_r;
  assign fr_dvd   = dvd4_r;
  assign fr_dvs   = dvs4_r;

endmodule

### design/cefl_div.sv
// pipelined restoring divider, one quotient bit per stage
module cefl_div
  import cefl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             dv_in_valid,
  input  side_t            dv_in_side,
  input  logic [Q_W-1:0]   dv_in_dvd,
  input  logic [CFG_W-1:0] dv_in_dvs,
  output logic             dv_valid,
  output side_t            dv_side,
  output logic [Q_W-1:0]   dv_quot
);

  logic [CFG_W-1:0] rem_i [DIV_STAGES+1];
  logic [Q_W-1:0]   dq_i  [DIV_STAGES+1];
  logic [CFG_W-1:0] dvs_i [DIV_STAGES+1];
  side_t            side_i [DIV_STAGES+1];
  logic             vld_i [DIV_STAGES+1];

  assign rem_i[0]  = '0;
  assign dq_i[0]   = dv_in_dvd;
  assign dvs_i[0]  = dv_in_dvs;
  assign side_i[0] = dv_in_side;
  assign vld_i[0]  = dv_in_valid;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [CFG_W:0]   trial;
    logic             ge;
    logic [CFG_W-1:0] rem_nxt;
    logic [CFG_W-1:0] rem_r;
    logic [Q_W-1:0]   dq_r;
    logic [CFG_W-1:0] dvs_r;
    side_t            side_r;
    logic             vld_r;

    always_comb begin
      trial   = {rem_i[k], dq_i[k][Q_W-1]};
      ge      = trial >= {1'b0, dvs_i[k]};
      rem_nxt = ge ? CFG_W'(trial - {1'b0, dvs_i[k]}) : trial[CFG_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= vld_i[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        dq_r   <= {dq_i[k][Q_W-2:0], ge};
        dvs_r  <= dvs_i[k];
        side_r <= side_i[k];
      end
    end

    assign rem_i[k+1]  = rem_r;
    assign dq_i[k+1]   = dq_r;
    assign dvs_i[k+1]  = dvs_r;
    assign side_i[k+1] = side_r;
    assign vld_i[k+1]  = vld_r;
  end

  assign dv_valid = vld_i[DIV_STAGES];
  assign dv_side  = side_i[DIV_STAGES];
  assign dv_quot  = dq_i[DIV_STAGES];

endmodule

### design/cefl_energy.sv
// back stages: internal energy, floor, limiter, rebuilt total energy
module cefl_energy
  import cefl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 dv_valid,
  input  side_t                dv_side,
  input  logic [Q_W-1:0]       dv_quot,
  input  logic [1:0]           hydro_mode,
  input  logic                 dual_en,
  input  logic [CFG_W-1:0]     e_floor,
  input  logic [CFG_W-1:0]     asq,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_new_density,
  output logic signed [DW-1:0] out_new_total_energy,
  output logic signed [DW-1:0] out_new_gas_energy,
  output logic                 out_outlier,
  output logic                 out_density_raised
);

  logic [Q_W-1:0]        ratio;
  logic [Q_W-2:0]        magt;
  logic signed [Q_W-1:0] eint;
  logic                  zeus;
  logic                  lim;

  logic signed [Q_W-1:0] eint1_r;
  logic [Q_W-2:0]        magt1_r;
  logic [SQ_W-1:0]       kin1_r;
  logic                  lim1_r, out1_r, zeus1_r, v1_r;
  logic signed [DW-1:0]  rho1_r, gas1_r, rlim1_r;

  logic signed [Q_W-1:0] floor_ext;
  logic signed [Q_W-1:0] eflo2_r;
  logic [Q_W-1:0]        add2_r;
  logic                  lim2_r, out2_r, v2_r;
  logic signed [DW-1:0]  rho2_r, gas2_r, rlim2_r;

  logic [Q_W-1:0]        enew3_r;
  logic [Q_W-1:0]        eflo3_r;
  logic                  lim3_r, out3_r, v3_r;
  logic signed [DW-1:0]  rho3_r, gas3_r, rlim3_r;

  logic                  v4_r;
  logic signed [DW-1:0]  dens4_r, etot4_r, gas4_r;
  logic                  out4_r, lim4_r;

  always_comb begin
    ratio = dv_quot[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : dv_quot;
    if (!dv_side.rho_pos) begin
      ratio = '0;
    end
    magt = ratio[Q_W-1:1];
    zeus = hydro_mode == HM_ZEUS;
    if (zeus) begin
      eint = Q_W'(dv_side.etot);
    end else if (dual_en) begin
      eint = Q_W'(dv_side.gas);
    end else begin
      eint = Q_W'(dv_side.etot) - $signed(Q_W'(dv_side.kin)) - $signed({1'b0, magt});
    end
    lim = (hydro_mode == HM_MHD) && dv_side.rho_pos && (ratio > Q_W'(asq));
  end

  assign floor_ext = $signed(Q_W'(e_floor));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= dv_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eint1_r <= eint;
      magt1_r <= magt;
      kin1_r  <= dv_side.kin;
      lim1_r  <= lim;
      zeus1_r <= zeus;
      out1_r  <= dv_side.etot[DW-1] || eint[Q_W-1] || dv_side.rho[DW-1];
      rho1_r  <= dv_side.rho;
      gas1_r  <= dv_side.gas;
      rlim1_r <= dv_side.rho_lim;

      eflo2_r <= (eint1_r < floor_ext) ? floor_ext : eint1_r;
      add2_r  <= zeus1_r ? '0 : Q_W'(kin1_r) +
                 (lim1_r ? Q_W'(asq[CFG_W-1:1]) : Q_W'(magt1_r));
      lim2_r  <= lim1_r;
      out2_r  <= out1_r;
      rho2_r  <= rho1_r;
      gas2_r  <= gas1_r;
      rlim2_r <= rlim1_r;

      enew3_r <= eflo2_r + add2_r;
      eflo3_r <= eflo2_r;
      lim3_r  <= lim2_r;
      out3_r  <= out2_r;
      rho3_r  <= rho2_r;
      gas3_r  <= gas2_r;
      rlim3_r <= rlim2_r;

      dens4_r <= lim3_r ? rlim3_r : rho3_r;
      etot4_r <= sat_pos(enew3_r);
      gas4_r  <= dual_en ? sat_pos(eflo3_r) : gas3_r;
      out4_r  <= out3_r;
      lim4_r  <= lim3_r;
    end
  end

  assign out_valid            = v4_r;
  assign out_new_density      = dens4_r;
  assign out_new_total_energy = etot4_r;
  assign out_new_gas_energy   = gas4_r;
  assign out_outlier          = out4_r;
  assign out_density_raised   = lim4_r;

endmodule

### design/cell_energy_floor_limiter_core.sv
// pipeline: 72 register stages from the input ports to the outputs
// throughput: one beat per cycle while no output stall holds the pipeline; the 64-stage divider sets the depth
// an output stall while out_valid is high freezes the whole pipeline, and in_stall follows it
// reset: all stage valid bits cleared, configuration registers take their reset values
// reset value of hydro_mode is ordinary, alfven_speed_sq all ones
`include "cell_energy_floor_limiter_core_macros.svh"
module cell_energy_floor_limiter_core
  import cefl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_density,
  input  logic signed [DW-1:0] in_vel_x,
  input  logic signed [DW-1:0] in_vel_y,
  input  logic signed [DW-1:0] in_vel_z,
  input  logic signed [DW-1:0] in_mag_x,
  input  logic signed [DW-1:0] in_mag_y,
  input  logic signed [DW-1:0] in_mag_z,
  input  logic signed [DW-1:0] in_total_energy,
  input  logic signed [DW-1:0] in_gas_energy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_new_density,
  output logic signed [DW-1:0] out_new_total_energy,
  output logic signed [DW-1:0] out_new_gas_energy,
  output logic                 out_outlier,
  output logic                 out_density_raised,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [1:0]       hydro_mode_r;
  logic             dual_r, mhd_r;
  logic [CFG_W-1:0] floor_r, asq_r, asq_inv_r;
  logic             wr_en;
  reg_idx_t         idx;
  logic             adv;

  logic             fr_valid;
  side_t            fr_side;
  logic [Q_W-1:0]   fr_dvd;
  logic [CFG_W-1:0] fr_dvs;
  logic             dv_valid;
  side_t            dv_side;
  logic [Q_W-1:0]   dv_quot;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hydro_mode_r <= HM_ORD;
      dual_r       <= 1'b0;
      mhd_r        <= 1'b0;
      floor_r      <= '0;
      asq_r        <= '1;
      asq_inv_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_HYDRO_MODE:    hydro_mode_r <= pwdata[1:0];
        REG_DUAL_ENERGY:   dual_r       <= pwdata[0];
        REG_MHD_ENABLED:   mhd_r        <= pwdata[0];
        REG_ENERGY_FLOOR:  floor_r      <= pwdata[CFG_W-1:0];
        REG_ALFVEN_SQ:     asq_r        <= pwdata[CFG_W-1:0];
        REG_ALFVEN_SQ_INV: asq_inv_r    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HYDRO_MODE:    prdata = {30'b0, hydro_mode_r};
      REG_DUAL_ENERGY:   prdata = {31'b0, dual_r};
      REG_MHD_ENABLED:   prdata = {31'b0, mhd_r};
      REG_ENERGY_FLOOR:  prdata = {1'b0, floor_r};
      REG_ALFVEN_SQ:     prdata = {1'b0, asq_r};
      REG_ALFVEN_SQ_INV: prdata = {1'b0, asq_inv_r};
      default:           prdata = '0;
    endcase
  end

  cefl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_density      (in_density),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_mag_x        (in_mag_x),
    .in_mag_y        (in_mag_y),
    .in_mag_z        (in_mag_z),
    .in_total_energy (in_total_energy),
    .in_gas_energy   (in_gas_energy),
    .mhd_en          (mhd_r),
    .asq_inv         (asq_inv_r),
    .fr_valid        (fr_valid),
    .fr_side         (fr_side),
    .fr_dvd          (fr_dvd),
    .fr_dvs          (fr_dvs)
  );

  cefl_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .dv_in_valid (fr_valid),
    .dv_in_side  (fr_side),
    .dv_in_dvd   (fr_dvd),
    .dv_in_dvs   (fr_dvs),
    .dv_valid    (dv_valid),
    .dv_side     (dv_side),
    .dv_quot     (dv_quot)
  );

  cefl_energy u_energy (
    .clk                  (clk),
    .rst_n                (rst_n),
    .adv                  (adv),
    .dv_valid             (dv_valid),
    .dv_side              (dv_side),
    .dv_quot              (dv_quot),
    .hydro_mode           (hydro_mode_r),
    .dual_en              (dual_r),
    .e_floor              (floor_r),
    .asq                  (asq_r),
    .out_valid            (out_valid),
    .out_new_density      (out_new_density),
    .out_new_total_energy (out_new_total_energy),
    .out_new_gas_energy   (out_new_gas_energy),
    .out_outlier          (out_outlier),
    .out_density_raised   (out_density_raised)
  );

  `CEFL_IMPLIES(a_raise_mode, out_valid && out_density_raised, hydro_mode_r == HM_MHD, "raise mode")
  `CEFL_IMPLIES(a_raise_pos, out_valid && out_density_raised, !out_new_density[DW-1], "raise sign")
  `CEFL_IMPLIES(a_etot_pos, out_valid, !out_new_total_energy[DW-1], "total energy negative")
  `CEFL_IMPLIES(a_stall_src, in_stall, out_valid && out_stall, "input stall without held beat")

endmodule
